### design/fsrm_pkg.sv
// ----------------------------------------------------------------------------
// fsrm_pkg
// Shared constants and types for the free slot run manager.
// ----------------------------------------------------------------------------
package fsrm_pkg;

   localparam int SLOTS = 64;
   localparam int IDX_W = 6;
   localparam int CNT_W = 7;
   localparam int ALU_W = CNT_W + 1;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [ALU_W-1:0] alu_word_type;

   // link value that means "no run"
   localparam cnt_type NO_RUN = cnt_type'(SLOTS);

   localparam logic CMD_ERASE   = 1'b0;
   localparam logic CMD_CONSUME = 1'b1;

   typedef struct packed {
      idx_type skip_ra;
      idx_type skip_rb;
      idx_type link_ra;
      logic    skip_we;
      idx_type skip_wa;
      cnt_type skip_wd;
      logic    prev_we;
      idx_type prev_wa;
      cnt_type prev_wd;
      logic    next_we;
      idx_type next_wa;
      cnt_type next_wd;
   } store_req_type;

   typedef struct packed {
      cnt_type skip_a;
      cnt_type skip_b;
      cnt_type prev_q;
      cnt_type next_q;
   } store_rsp_type;

   typedef struct packed {
      alu_word_type a;
      alu_word_type b;
      logic         sub;
      logic         cin;
   } alu_req_type;

endpackage

### design/fsrm_alu.sv
// ----------------------------------------------------------------------------
// fsrm_alu
// Shared add/subtract unit used by the adder steps of the sequencer.
// ----------------------------------------------------------------------------
module fsrm_alu
   import fsrm_pkg::*;
(
   input  alu_req_type  alu_req,
   output alu_word_type alu_sum
);

   alu_word_type b_op;

   assign b_op    = alu_req.sub ? ~alu_req.b : alu_req.b;
   assign alu_sum = alu_req.a + b_op + alu_word_type'(alu_req.sub | alu_req.cin);

endmodule

### design/fsrm_store.sv
// ----------------------------------------------------------------------------
// fsrm_store
// Skip store (two read ports, valid bit per entry) and the prev/next link
// memories. All read data is registered.
// ----------------------------------------------------------------------------
module fsrm_store
   import fsrm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  store_req_type store_req,
   output store_rsp_type store_rsp
);

   cnt_type          skip_mem_ff [SLOTS];
   cnt_type          prev_mem_ff [SLOTS];
   cnt_type          next_mem_ff [SLOTS];
   logic [SLOTS-1:0] skip_vld_ff;

   cnt_type skip_a_ff;
   cnt_type skip_b_ff;
   logic    vld_a_ff;
   logic    vld_b_ff;
   cnt_type prev_q_ff;
   cnt_type next_q_ff;

   always_ff @(posedge clock) begin
      if (store_req.skip_we) begin
         skip_mem_ff[store_req.skip_wa] <= store_req.skip_wd;
      end
      skip_a_ff <= skip_mem_ff[store_req.skip_ra];
      skip_b_ff <= skip_mem_ff[store_req.skip_rb];
      vld_a_ff  <= skip_vld_ff[store_req.skip_ra];
      vld_b_ff  <= skip_vld_ff[store_req.skip_rb];
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         skip_vld_ff <= '0;
      end else if (store_req.skip_we) begin
         skip_vld_ff[store_req.skip_wa] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (store_req.prev_we) begin
         prev_mem_ff[store_req.prev_wa] <= store_req.prev_wd;
      end
      prev_q_ff <= prev_mem_ff[store_req.link_ra];
   end

   always_ff @(posedge clock) begin
      if (store_req.next_we) begin
         next_mem_ff[store_req.next_wa] <= store_req.next_wd;
      end
      next_q_ff <= next_mem_ff[store_req.link_ra];
   end

   assign store_rsp.skip_a = vld_a_ff ? skip_a_ff : '0;
   assign store_rsp.skip_b = vld_b_ff ? skip_b_ff : '0;
   assign store_rsp.prev_q = prev_q_ff;
   assign store_rsp.next_q = next_q_ff;

endmodule

### design/free_slot_run_manager.sv
// ----------------------------------------------------------------------------
// free_slot_run_manager
// Erase/consume bookkeeping of free slot runs: skip store plus a doubly
// linked list of run starts, driven by a small sequencer around one adder.
// Flow: a request is fetched and checked; a rejected one goes straight to the
//   response word, others first take adder steps, link and skip writes. The
//   response word is not loaded while the previous one is held by rsp_stall.
// Throughput: one request at a time; req_stall stays high until the response
//   word is loaded.
// Reset: synchronous; the skip store reads as all zero and the free list is empty.
// ----------------------------------------------------------------------------
module free_slot_run_manager
   import fsrm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic          req_command,
   input  logic [5:0]    req_slot_index,
   input  logic [6:0]    req_used_count,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic          rsp_status,
   output logic          rsp_any_free,
   output logic [6:0]    rsp_first_free,
   output logic [6:0]    rsp_run_length
);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_FETCH   = 4'd1;
   localparam logic [3:0] ST_CHECK   = 4'd2;
   localparam logic [3:0] ST_E_START = 4'd3;
   localparam logic [3:0] ST_E_FIN   = 4'd4;
   localparam logic [3:0] ST_E_LEN   = 4'd5;
   localparam logic [3:0] ST_C_END   = 4'd6;
   localparam logic [3:0] ST_C_CLAMP = 4'd7;
   localparam logic [3:0] ST_C_DEC   = 4'd8;
   localparam logic [3:0] ST_C_LAST  = 4'd9;
   localparam logic [3:0] ST_LINK1   = 4'd10;
   localparam logic [3:0] ST_LINK2   = 4'd11;
   localparam logic [3:0] ST_SK1     = 4'd12;
   localparam logic [3:0] ST_SK2     = 4'd13;
   localparam logic [3:0] ST_SK3     = 4'd14;
   localparam logic [3:0] ST_DONE    = 4'd15;

   localparam logic [1:0] LOP_NONE   = 2'd0;
   localparam logic [1:0] LOP_PUSH   = 2'd1;
   localparam logic [1:0] LOP_MOVE   = 2'd2;
   localparam logic [1:0] LOP_UNLINK = 2'd3;

   logic [3:0] state_ff, state_in;
   logic       cmd_ff, cmd_in;
   idx_type    idx_ff, idx_in;
   cnt_type    used_ff, used_in;
   cnt_type    cur_ff, cur_in;
   cnt_type    left_ff, left_in;
   cnt_type    right_ff, right_in;
   idx_type    start_ff, start_in;
   idx_type    finish_ff, finish_in;
   cnt_type    len_ff, len_in;
   cnt_type    p_ff, p_in;
   cnt_type    n_ff, n_in;
   cnt_type    head_ff, head_in;
   logic       ok_ff, ok_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_status_ff, rsp_status_in;
   logic       rsp_any_free_ff, rsp_any_free_in;
   cnt_type    rsp_first_free_ff, rsp_first_free_in;
   cnt_type    rsp_run_length_ff, rsp_run_length_in;

   store_req_type store_req;
   store_rsp_type store_rsp;
   alu_req_type   alu_req;
   alu_word_type  alu_sum;

   idx_type    idx_p1;
   idx_type    move_to;
   logic [1:0] lop;
   logic       accept;
   logic       rsp_load;

   fsrm_store u_store (
      .clock     (clock),
      .reset     (reset),
      .store_req (store_req),
      .store_rsp (store_rsp)
   );

   fsrm_alu u_alu (
      .alu_req (alu_req),
      .alu_sum (alu_sum)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign idx_p1    = idx_ff + idx_type'(1);
   assign move_to   = (cmd_ff == CMD_CONSUME) ? idx_p1 : idx_ff;
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // list edit for this command
   always_comb begin
      if (cmd_ff == CMD_CONSUME) begin
         lop = (len_ff == '0) ? LOP_UNLINK : LOP_MOVE;
      end else if (left_ff == '0 && right_ff == '0) begin
         lop = LOP_PUSH;
      end else if (left_ff == '0) begin
         lop = LOP_MOVE;
      end else if (right_ff != '0) begin
         lop = LOP_UNLINK;
      end else begin
         lop = LOP_NONE;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      idx_in    = idx_ff;
      used_in   = used_ff;
      cur_in    = cur_ff;
      left_in   = left_ff;
      right_in  = right_ff;
      start_in  = start_ff;
      finish_in = finish_ff;
      len_in    = len_ff;
      p_in      = p_ff;
      n_in      = n_ff;
      head_in   = head_ff;
      ok_in     = ok_ff;

      store_req         = '0;
      store_req.skip_ra = idx_ff;
      store_req.skip_rb = idx_ff;
      store_req.link_ra = idx_ff;

      alu_req = '0;

      case (state_ff)
         ST_IDLE: begin
            store_req.skip_ra = req_slot_index;
            store_req.skip_rb = req_slot_index - idx_type'(1);
            store_req.link_ra = (req_command == CMD_CONSUME) ? req_slot_index
                                                             : req_slot_index + idx_type'(1);
            if (accept) begin
               cmd_in   = req_command;
               idx_in   = req_slot_index;
               used_in  = (req_used_count > cnt_type'(SLOTS)) ? cnt_type'(SLOTS)
                                                              : req_used_count;
               ok_in    = 1'b1;
               state_in = ST_FETCH;
            end
         end

         ST_FETCH: begin
            store_req.skip_ra = idx_p1;
            cur_in   = store_rsp.skip_a;
            left_in  = (idx_ff != '0) ? store_rsp.skip_b : '0;
            p_in     = store_rsp.prev_q;
            n_in     = store_rsp.next_q;
            state_in = ST_CHECK;
         end

         ST_CHECK: begin
            right_in = ((cnt_type'(idx_ff) + cnt_type'(1)) < used_ff) ? store_rsp.skip_a : '0;
            len_in   = cur_ff;
            if (cmd_ff == CMD_ERASE) begin
               if (cur_ff != '0) begin
                  ok_in    = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_E_START;
               end
            end else begin
               if (cur_ff == '0 || left_ff != '0) begin
                  ok_in    = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_C_END;
               end
            end
         end

         ST_E_START: begin
            alu_req.a   = alu_word_type'(idx_ff);
            alu_req.b   = alu_word_type'(left_ff);
            alu_req.sub = 1'b1;
            // left run longer than the slots below: clip at slot 0
            if (alu_sum[ALU_W-1]) begin
               left_in  = cnt_type'(idx_ff);
               start_in = '0;
            end else begin
               start_in = alu_sum[IDX_W-1:0];
            end
            state_in = ST_E_FIN;
         end

         ST_E_FIN: begin
            alu_req.a = alu_word_type'(idx_ff);
            alu_req.b = alu_word_type'(right_ff);
            if (alu_sum >= alu_word_type'(SLOTS)) begin
               right_in  = cnt_type'(idx_type'(~idx_ff));
               finish_in = '1;
            end else begin
               finish_in = alu_sum[IDX_W-1:0];
            end
            state_in = ST_E_LEN;
         end

         ST_E_LEN: begin
            alu_req.a   = alu_word_type'(left_ff);
            alu_req.b   = alu_word_type'(right_ff);
            alu_req.cin = 1'b1;
            len_in      = alu_sum[CNT_W-1:0];
            state_in    = ST_LINK1;
         end

         ST_C_END: begin
            alu_req.a = alu_word_type'(idx_ff);
            alu_req.b = alu_word_type'(len_ff);
            state_in  = (alu_sum > alu_word_type'(SLOTS)) ? ST_C_CLAMP : ST_C_DEC;
         end

         ST_C_CLAMP: begin
            alu_req.a   = alu_word_type'(SLOTS);
            alu_req.b   = alu_word_type'(idx_ff);
            alu_req.sub = 1'b1;
            len_in      = alu_sum[CNT_W-1:0];
            state_in    = ST_C_DEC;
         end

         ST_C_DEC: begin
            // len_ff holds the remaining length from here on
            alu_req.a   = alu_word_type'(len_ff);
            alu_req.b   = alu_word_type'(1);
            alu_req.sub = 1'b1;
            len_in      = alu_sum[CNT_W-1:0];
            state_in    = ST_C_LAST;
         end

         ST_C_LAST: begin
            alu_req.a = alu_word_type'(idx_ff);
            alu_req.b = alu_word_type'(len_ff);
            finish_in = alu_sum[IDX_W-1:0];
            state_in  = ST_LINK1;
         end

         ST_LINK1: begin
            state_in = ST_SK1;
            case (lop)
               LOP_PUSH: begin
                  store_req.prev_we = 1'b1;
                  store_req.prev_wa = idx_ff;
                  store_req.prev_wd = NO_RUN;
                  store_req.next_we = 1'b1;
                  store_req.next_wa = idx_ff;
                  store_req.next_wd = head_ff;
                  state_in          = ST_LINK2;
               end
               LOP_MOVE: begin
                  store_req.prev_we = 1'b1;
                  store_req.prev_wa = move_to;
                  store_req.prev_wd = p_ff;
                  store_req.next_we = 1'b1;
                  store_req.next_wa = move_to;
                  store_req.next_wd = n_ff;
                  state_in          = ST_LINK2;
               end
               LOP_UNLINK: begin
                  if (!p_ff[CNT_W-1]) begin
                     store_req.next_we = 1'b1;
                     store_req.next_wa = p_ff[IDX_W-1:0];
                     store_req.next_wd = n_ff;
                  end else begin
                     head_in = n_ff;
                  end
                  if (!n_ff[CNT_W-1]) begin
                     store_req.prev_we = 1'b1;
                     store_req.prev_wa = n_ff[IDX_W-1:0];
                     store_req.prev_wd = p_ff;
                  end
                  // a removed run only clears its own slot
                  state_in = (cmd_ff == CMD_CONSUME) ? ST_SK3 : ST_SK1;
               end
               default: begin
                  state_in = ST_SK1;
               end
            endcase
         end

         ST_LINK2: begin
            case (lop)
               LOP_PUSH: begin
                  if (!head_ff[CNT_W-1]) begin
                     store_req.prev_we = 1'b1;
                     store_req.prev_wa = head_ff[IDX_W-1:0];
                     store_req.prev_wd = cnt_type'(idx_ff);
                  end
                  head_in = cnt_type'(idx_ff);
               end
               LOP_MOVE: begin
                  if (!p_ff[CNT_W-1]) begin
                     store_req.next_we = 1'b1;
                     store_req.next_wa = p_ff[IDX_W-1:0];
                     store_req.next_wd = cnt_type'(move_to);
                  end else begin
                     head_in = cnt_type'(move_to);
                  end
                  if (!n_ff[CNT_W-1]) begin
                     store_req.prev_we = 1'b1;
                     store_req.prev_wa = n_ff[IDX_W-1:0];
                     store_req.prev_wd = cnt_type'(move_to);
                  end
               end
               default: begin
               end
            endcase
            state_in = ST_SK1;
         end

         ST_SK1: begin
            store_req.skip_we = 1'b1;
            store_req.skip_wa = (cmd_ff == CMD_CONSUME) ? idx_p1 : idx_ff;
            store_req.skip_wd = (cmd_ff == CMD_CONSUME) ? len_ff : cnt_type'(1);
            state_in          = ST_SK2;
         end

         ST_SK2: begin
            store_req.skip_we = 1'b1;
            store_req.skip_wa = (cmd_ff == CMD_CONSUME) ? finish_ff : start_ff;
            store_req.skip_wd = len_ff;
            state_in          = ST_SK3;
         end

         ST_SK3: begin
            store_req.skip_we = 1'b1;
            store_req.skip_wa = (cmd_ff == CMD_CONSUME) ? idx_ff : finish_ff;
            store_req.skip_wd = (cmd_ff == CMD_CONSUME) ? cnt_type'(0) : len_ff;
            state_in          = ST_DONE;
         end

         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response word register
   always_comb begin
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_status_in     = rsp_status_ff;
      rsp_any_free_in   = rsp_any_free_ff;
      rsp_first_free_in = rsp_first_free_ff;
      rsp_run_length_in = rsp_run_length_ff;
      if (rsp_load) begin
         rsp_valid_in      = 1'b1;
         rsp_status_in     = !ok_ff;
         rsp_any_free_in   = !head_ff[CNT_W-1];
         rsp_first_free_in = head_ff;
         rsp_run_length_in = ok_ff ? len_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= NO_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff            <= cmd_in;
      idx_ff            <= idx_in;
      used_ff           <= used_in;
      cur_ff            <= cur_in;
      left_ff           <= left_in;
      right_ff          <= right_in;
      start_ff          <= start_in;
      finish_ff         <= finish_in;
      len_ff            <= len_in;
      p_ff              <= p_in;
      n_ff              <= n_in;
      ok_ff             <= ok_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_any_free_ff   <= rsp_any_free_in;
      rsp_first_free_ff <= rsp_first_free_in;
      rsp_run_length_ff <= rsp_run_length_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_any_free   = rsp_any_free_ff;
   assign rsp_first_free = rsp_first_free_ff;
   assign rsp_run_length = rsp_run_length_ff;

endmodule

### dv/fsrm_run_checker.sv
// ----------------------------------------------------------------------------
// fsrm_run_checker
// Watches the request and response channels of the free slot run manager,
// keeps its own copy of the skip store and run list, predicts one response
// word per accepted request and compares it field by field.
// ----------------------------------------------------------------------------
module fsrm_run_checker
   import fsrm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic       req_command,
   input  logic [5:0] req_slot_index,
   input  logic [6:0] req_used_count,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       rsp_status,
   input  logic       rsp_any_free,
   input  logic [6:0] rsp_first_free,
   input  logic [6:0] rsp_run_length,
   output int         fail_count,
   output int         outstanding
);

   localparam logic STATUS_DONE   = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   typedef struct packed {
      logic    status;
      logic    any_free;
      cnt_type first_free;
      cnt_type run_length;
   } run_report_type;

   cnt_type        skip_len [SLOTS];
   cnt_type        prev_run [SLOTS];
   cnt_type        next_run [SLOTS];
   cnt_type        free_head;
   run_report_type predicted_reports [$];
   int             errors = 0;

   function automatic void list_push(int unsigned s);
      prev_run[s] = NO_RUN;
      next_run[s] = free_head;
      if (free_head < SLOTS) begin
         prev_run[free_head] = cnt_type'(s);
      end
      free_head = cnt_type'(s);
   endfunction

   function automatic void list_drop(int unsigned s);
      cnt_type p;
      cnt_type n;
      p = prev_run[s];
      n = next_run[s];
      if (p < SLOTS) begin
         next_run[p] = n;
      end else begin
         free_head = n;
      end
      if (n < SLOTS) begin
         prev_run[n] = p;
      end
   endfunction

   // the run start moves from one slot to another, keeping its list position
   function automatic void list_move(int unsigned from, int unsigned to);
      cnt_type p;
      cnt_type n;
      p = prev_run[from];
      n = next_run[from];
      prev_run[to] = p;
      next_run[to] = n;
      if (p < SLOTS) begin
         next_run[p] = cnt_type'(to);
      end else begin
         free_head = cnt_type'(to);
      end
      if (n < SLOTS) begin
         prev_run[n] = cnt_type'(to);
      end
   endfunction

   function automatic bit erase_slot(int unsigned idx, int unsigned used,
                                     output int unsigned len);
      int unsigned l;
      int unsigned r;
      int unsigned first;
      int unsigned last;
      len = 0;
      if (idx >= SLOTS || skip_len[idx] != 0) return 1'b0;
      if (used > SLOTS) used = SLOTS;
      l = (idx > 0) ? skip_len[idx-1] : 0;
      r = (idx + 1 < used) ? skip_len[idx+1] : 0;
      if (l > idx) l = idx;
      if (idx + r >= SLOTS) r = SLOTS - 1 - idx;
      first = idx - l;
      last  = idx + r;
      len   = l + 1 + r;
      if (l == 0 && r == 0) begin
         list_push(idx);
      end else if (l == 0) begin
         list_move(idx + 1, idx);
      end else if (r != 0) begin
         list_drop(idx + 1);
      end
      skip_len[idx]   = 7'd1;
      skip_len[first] = cnt_type'(len);
      skip_len[last]  = cnt_type'(len);
      return 1'b1;
   endfunction

   function automatic bit consume_slot(int unsigned s, output int unsigned len);
      int unsigned span;
      len = 0;
      if (s >= SLOTS || skip_len[s] == 0) return 1'b0;
      if (s > 0 && skip_len[s-1] != 0) return 1'b0;
      span = skip_len[s];
      if (s + span > SLOTS) span = SLOTS - s;
      if (span <= 1) begin
         list_drop(s);
      end else begin
         list_move(s, s + 1);
         skip_len[s+1]      = cnt_type'(span - 1);
         skip_len[s+span-1] = cnt_type'(span - 1);
         len = span - 1;
      end
      skip_len[s] = '0;
      return 1'b1;
   endfunction

   function automatic void check_field(string field, cnt_type want, cnt_type got);
      if (got !== want) begin
         errors++;
         $display("%0t rsp %s mismatch: expected %0d, actual %0d",
                  $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin : watch
      run_report_type want;
      int unsigned    len;
      bit             ok;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            skip_len[i] = '0;
            prev_run[i] = '0;
            next_run[i] = '0;
         end
         free_head = NO_RUN;
         predicted_reports.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_reports.size() == 0) begin
               errors++;
               $display("%0t rsp word with none pending: expected none, actual %0b %0b %0d %0d",
                        $time, rsp_status, rsp_any_free, rsp_first_free, rsp_run_length);
            end else begin
               want = predicted_reports.pop_front();
               check_field("status", cnt_type'(want.status), cnt_type'(rsp_status));
               check_field("any_free", cnt_type'(want.any_free), cnt_type'(rsp_any_free));
               check_field("first_free", want.first_free, rsp_first_free);
               check_field("run_length", want.run_length, rsp_run_length);
            end
         end
         if (req_valid && !req_stall) begin
            if (req_command == CMD_ERASE) begin
               ok = erase_slot(req_slot_index, req_used_count, len);
            end else begin
               ok = consume_slot(req_slot_index, len);
            end
            want.status     = ok ? STATUS_DONE : STATUS_REJECT;
            want.any_free   = (free_head < SLOTS);
            want.first_free = free_head;
            want.run_length = ok ? cnt_type'(len) : '0;
            predicted_reports.push_back(want);
         end
      end
      fail_count  <= errors;
      outstanding <= predicted_reports.size();
   end

endmodule

### dv/tb_free_slot_run_manager.sv
// ----------------------------------------------------------------------------
// tb_free_slot_run_manager
// Drives erase and consume words into the free slot run manager: a directed
// pass over merges, shrinks and rejected requests, then random fill and drain
// phases with random gaps on both channels and one long response hold-off.
// ----------------------------------------------------------------------------
module tb_free_slot_run_manager
   import fsrm_pkg::*;
;

   localparam int RANDOM_WORDS = 550;
   localparam int HOLD_AT      = 300;
   localparam int HOLD_LEN     = 400;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic       req_command;
   logic [5:0] req_slot_index;
   logic [6:0] req_used_count;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_status;
   logic       rsp_any_free;
   logic [6:0] rsp_first_free;
   logic [6:0] rsp_run_length;
   int         fail_count;
   int         outstanding;

   bit [SLOTS-1:0] freed_map = '0;   // slots currently erased
   bit             calm = 1'b0;      // no idling on either side

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   free_slot_run_manager u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_slot_index (req_slot_index),
      .req_used_count (req_used_count),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_any_free   (rsp_any_free),
      .rsp_first_free (rsp_first_free),
      .rsp_run_length (rsp_run_length)
   );

   fsrm_run_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_slot_index (req_slot_index),
      .req_used_count (req_used_count),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_any_free   (rsp_any_free),
      .rsp_first_free (rsp_first_free),
      .rsp_run_length (rsp_run_length),
      .fail_count     (fail_count),
      .outstanding    (outstanding)
   );

   task automatic send_word(input logic cmd, input int unsigned slot,
                            input int unsigned used);
      int unsigned gap;
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_slot_index <= 6'(slot);
      req_used_count <= 7'(used);
      do @(posedge clock); while (req_stall);
      // track which slots are erased so random words can aim at run starts
      if (cmd == CMD_ERASE) begin
         freed_map[slot] = 1'b1;
      end else if (freed_map[slot] && (slot == 0 || !freed_map[slot-1])) begin
         freed_map[slot] = 1'b0;
      end
   endtask

   function automatic int unsigned pick_slot(bit want_start);
      int unsigned base;
      int unsigned s;
      base = $urandom_range(0, SLOTS - 1);
      for (int k = 0; k < SLOTS; k++) begin
         s = (base + k) % SLOTS;
         if (want_start ? (freed_map[s] && (s == 0 || !freed_map[s-1])) : !freed_map[s])
            return s;
      end
      return base;
   endfunction

   // response side: random stalls, one long hold-off so the block backs up
   initial begin : drain_side
      int unsigned gap;
      int unsigned taken;
      taken = 0;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = (taken == HOLD_AT) ? HOLD_LEN : (calm ? 0 : $urandom_range(0, 6));
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   initial begin : stimulus
      int unsigned slot;
      int unsigned used;
      int unsigned fill_goal;
      int unsigned wait_cycles;
      bit          do_erase;
      bit          noise;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_command    <= CMD_ERASE;
      req_slot_index <= '0;
      req_used_count <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_word(CMD_CONSUME, 0, 64);    // empty list
      send_word(CMD_ERASE, 63, 127);    // used count above the block size
      send_word(CMD_ERASE, 0, 0);
      send_word(CMD_ERASE, 0, 64);      // already erased
      send_word(CMD_ERASE, 1, 64);      // grows run at 0
      send_word(CMD_ERASE, 62, 64);     // run start moves down to 62
      send_word(CMD_ERASE, 10, 64);
      send_word(CMD_ERASE, 12, 64);
      send_word(CMD_ERASE, 11, 64);     // bridges two runs
      send_word(CMD_CONSUME, 11, 64);   // interior slot
      send_word(CMD_CONSUME, 10, 64);   // shrink
      send_word(CMD_ERASE, 21, 64);
      send_word(CMD_ERASE, 20, 20);     // right side beyond used count, no merge
      send_word(CMD_CONSUME, 21, 64);   // left neighbor still erased
      send_word(CMD_CONSUME, 20, 64);
      send_word(CMD_CONSUME, 21, 64);
      send_word(CMD_CONSUME, 5, 64);    // slot in use
      send_word(CMD_ERASE, 42, 43);
      send_word(CMD_ERASE, 41, 127);
      send_word(CMD_CONSUME, 0, 64);
      send_word(CMD_CONSUME, 1, 64);
      send_word(CMD_CONSUME, 62, 64);
      send_word(CMD_CONSUME, 63, 64);
      send_word(CMD_CONSUME, 11, 64);
      send_word(CMD_CONSUME, 12, 64);

      fill_goal = SLOTS / 2;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 64 == 0) begin
            case ($urandom_range(0, 2))
               0:       fill_goal = 2;
               1:       fill_goal = SLOTS / 2;
               default: fill_goal = SLOTS;
            endcase
         end
         calm <= (n >= 200 && n < 280);
         noise = ($urandom_range(0, 9) == 0);
         if ($countones(freed_map) < fill_goal) begin
            do_erase = ($urandom_range(0, 9) < 8);
         end else begin
            do_erase = ($urandom_range(0, 9) < 3);
         end
         if (freed_map == '0) do_erase = 1'b1;
         if (&freed_map) do_erase = 1'b0;
         slot = noise ? $urandom_range(0, SLOTS - 1) : pick_slot(!do_erase);
         case ($urandom_range(0, 7))
            0:       used = $urandom_range(0, 127);
            1:       used = slot + 1;
            default: used = SLOTS;
         endcase
         send_word(do_erase ? CMD_ERASE : CMD_CONSUME, slot, used);
      end
      req_valid <= 1'b0;

      wait_cycles = 0;
      do begin
         @(posedge clock);
         wait_cycles++;
      end while (outstanding != 0 && wait_cycles < 5000);
      repeat (30) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule
